/* rtl/rds_pkg.sv */
// ----------------------------------------------------------------------------
// Rotating drum store package
// Shared widths, geometry, function and status codes and the command word
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rds_pkg;

  // drum geometry
  localparam int BAND_SIZE      = 50;
  localparam int SMALL_BANDS    = 40;
  localparam int LARGE_BANDS    = 80;
  localparam int PUNCH_OFFSET   = 26;
  localparam int READ_OFFSET    = 0;
  localparam int BUF_INDEX_MIN  = 1;
  localparam int BUF_INDEX_MAX  = 10;

  // field widths
  localparam int FUNC_W   = 3;
  localparam int ADDR_W   = 14;
  localparam int IDX_W    = 6;
  localparam int WORD_W   = 41;
  localparam int STATUS_W = 3;

  localparam int MAX_BANDS   = (SMALL_BANDS > LARGE_BANDS) ? SMALL_BANDS : LARGE_BANDS;
  localparam int STORE_DEPTH = (MAX_BANDS + 1) * BAND_SIZE;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = $clog2(BAND_SIZE);
  localparam int BAND_W      = $clog2((2 ** ADDR_W - 1) / BAND_SIZE + 1);
  localparam int EXTRA_BASE  = MAX_BANDS * BAND_SIZE;

  // address / BAND_SIZE as a multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = ADDR_W + 7;
  localparam int RECIP_VAL   = (2 ** RECIP_SHIFT + BAND_SIZE - 1) / BAND_SIZE;
  localparam int RECIP_W     = $clog2(RECIP_VAL + 1);
  localparam int PROD_W      = ADDR_W + RECIP_W;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET_RBUF  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STORE_RBUF = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_PBUF = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_GET_PBUF  = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDR_OOB  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDR_HEAD = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUF_HEAD  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BUF_OOB   = 3'd4;

  // back-end command kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] CMD_READ  = 2'd1;
  localparam logic [KIND_W-1:0] CMD_WRITE = 2'd2;
  localparam logic [KIND_W-1:0] CMD_COPY  = 2'd3;

  localparam int CMD_FIFO_DEPTH = 2;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_DRUM_LARGE = 1'd0;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   rd_slot;
    logic [SLOT_W-1:0]   wr_slot;
    logic [WORD_W-1:0]   data;
    logic [STATUS_W-1:0] status;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/rds_req_if.sv */
// ----------------------------------------------------------------------------
// Drum request channel
// Valid/ready channel carrying one drum operation per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rds_req_if;
  import rds_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] address;
  logic [IDX_W-1:0]  buffer_index;
  logic [WORD_W-1:0] data;

  modport source (output valid, func, address, buffer_index, data, input ready);
  modport sink   (input valid, func, address, buffer_index, data, output ready);
endinterface

`default_nettype wire

/* rtl/rds_rsp_if.sv */
// ----------------------------------------------------------------------------
// Drum response channel
// Valid/ready channel carrying one result word and status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rds_rsp_if;
  import rds_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   read_data;
  logic [STATUS_W-1:0] status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

`default_nettype wire

/* rtl/rds_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rds_front.sv */
// ----------------------------------------------------------------------------
// Drum front end
// Accepts requests, splits the address into band and angle, tracks the
// rotation position and turns each beat into one back-end command.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_front (
  input  wire logic          clk,
  input  wire logic          rst,
  rds_req_if.sink            req,
  input  wire logic          clearing,
  input  wire logic          drum_large,
  output logic               push_valid,
  input  wire logic          push_ready,
  output rds_pkg::cmd_t      push_cmd
);
  import rds_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP_VAL);

  // stage 1: registered request plus band quotient
  logic              s1_valid;
  logic [FUNC_W-1:0] s1_func;
  logic [ADDR_W-1:0] s1_addr;
  logic [IDX_W-1:0]  s1_idx;
  logic [WORD_W-1:0] s1_data;
  logic [BAND_W-1:0] s1_band;

  logic [POS_W-1:0]  pos;

  logic [PROD_W-1:0] prod;
  logic              s1_adv;
  logic              take;

  logic [ADDR_W-1:0] band_base;
  logic [ADDR_W-1:0] rem_full;
  logic [POS_W-1:0]  rem;
  logic [SLOT_W-1:0] word_slot;
  logic [SLOT_W-1:0] extra_slot;
  logic [BAND_W-1:0] bands;
  logic              band_ok;
  logic              idx_ok;
  logic              rbuf_hit;
  logic              pbuf_hit;
  cmd_t              cmd;

  assign s1_adv    = s1_valid && push_ready;
  assign req.ready = (!s1_valid || s1_adv) && !clearing;
  assign take      = req.valid && req.ready;

  assign prod = PROD_W'(req.address) * PROD_W'(RECIP_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_func <= req.func;
      s1_addr <= req.address;
      s1_idx  <= req.buffer_index;
      s1_data <= req.data;
      s1_band <= prod[RECIP_SHIFT +: BAND_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (s1_adv && s1_func == FUNC_TICK) begin
      pos <= (pos == POS_W'(BAND_SIZE - 1)) ? '0 : pos + POS_W'(1);
    end
  end

  // stage 2: head and range checks
  assign band_base  = ADDR_W'(s1_band) * ADDR_W'(BAND_SIZE);
  assign rem_full   = s1_addr - band_base;
  assign rem        = rem_full[POS_W-1:0];
  assign word_slot  = SLOT_W'(band_base) + SLOT_W'(pos);
  assign extra_slot = SLOT_W'(EXTRA_BASE) + SLOT_W'(pos);
  assign bands      = drum_large ? BAND_W'(LARGE_BANDS) : BAND_W'(SMALL_BANDS);
  assign band_ok    = s1_band < bands;
  assign idx_ok     = (s1_idx >= IDX_W'(BUF_INDEX_MIN)) && (s1_idx <= IDX_W'(BUF_INDEX_MAX));
  assign rbuf_hit   = ({1'b0, s1_idx} + (IDX_W + 1)'(READ_OFFSET)) == (IDX_W + 1)'(pos);
  assign pbuf_hit   = ({1'b0, s1_idx} + (IDX_W + 1)'(PUNCH_OFFSET)) == (IDX_W + 1)'(pos);

  always_comb begin
    cmd         = '0;
    cmd.kind    = CMD_NONE;
    cmd.status  = ST_OK;
    cmd.data    = s1_data;
    cmd.rd_slot = word_slot;
    cmd.wr_slot = word_slot;
    case (s1_func)
      FUNC_READ, FUNC_WRITE: begin
        if (rem != pos) begin
          cmd.status = ST_ADDR_HEAD;
        end else if (!band_ok) begin
          cmd.status = ST_ADDR_OOB;
        end else begin
          cmd.kind = (s1_func == FUNC_READ) ? CMD_READ : CMD_WRITE;
        end
      end
      FUNC_SET_RBUF: begin
        if (!rbuf_hit) begin
          cmd.status = ST_BUF_HEAD;
        end else if (!idx_ok) begin
          cmd.status = ST_BUF_OOB;
        end else begin
          cmd.kind    = CMD_WRITE;
          cmd.wr_slot = extra_slot;
        end
      end
      FUNC_STORE_RBUF: begin
        if (!rbuf_hit) begin
          cmd.status = ST_BUF_HEAD;
        end else if (!idx_ok) begin
          cmd.status = ST_BUF_OOB;
        end else if (!band_ok) begin
          cmd.status = ST_ADDR_OOB;
        end else begin
          cmd.kind    = CMD_COPY;
          cmd.rd_slot = extra_slot;
        end
      end
      FUNC_LOAD_PBUF: begin
        if (!pbuf_hit) begin
          cmd.status = ST_BUF_HEAD;
        end else if (!idx_ok) begin
          cmd.status = ST_BUF_OOB;
        end else if (!band_ok) begin
          cmd.status = ST_ADDR_OOB;
        end else begin
          cmd.kind    = CMD_COPY;
          cmd.wr_slot = extra_slot;
        end
      end
      FUNC_GET_PBUF: begin
        if (!pbuf_hit) begin
          cmd.status = ST_BUF_HEAD;
        end else if (!idx_ok) begin
          cmd.status = ST_BUF_OOB;
        end else begin
          cmd.kind    = CMD_READ;
          cmd.rd_slot = extra_slot;
        end
      end
      default: begin
        // tick and unused code: plain ok answer
        cmd.kind = CMD_NONE;
      end
    endcase
  end

  assign push_valid = s1_valid;
  assign push_cmd   = cmd;

endmodule

`default_nettype wire

/* rtl/rds_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Drum command queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire rds_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop,
  output rds_pkg::cmd_t      pop_cmd
);
  import rds_pkg::*;

  localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t             entries [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(CMD_FIFO_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/rds_back.sv */
// ----------------------------------------------------------------------------
// Drum back end
// Clears the store after reset, then executes queued commands against the
// drum RAM and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  input  wire rds_pkg::cmd_t cmd,
  output logic               clearing,
  rds_rsp_if.source          rsp
);
  import rds_pkg::*;

  localparam logic [1:0] BK_CLEAR = 2'd0;
  localparam logic [1:0] BK_IDLE  = 2'd1;
  localparam logic [1:0] BK_WAIT  = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [SLOT_W-1:0]   clr_cnt;

  logic [KIND_W-1:0]   held_kind;
  logic [SLOT_W-1:0]   held_wr_slot;

  logic                we;
  logic [SLOT_W-1:0]   waddr;
  logic [WORD_W-1:0]   wdata;
  logic                re;
  logic [WORD_W-1:0]   rdata;

  logic                rsp_valid;
  logic [WORD_W-1:0]   rsp_data;
  logic [STATUS_W-1:0] rsp_status;
  logic                load;
  logic [WORD_W-1:0]   load_data;
  logic [STATUS_W-1:0] load_status;
  logic                slot_free;

  assign clearing  = (state == BK_CLEAR);
  assign slot_free = !rsp_valid || rsp.ready;
  assign cmd_pop   = (state == BK_IDLE) && cmd_valid && slot_free;
  assign re        = cmd_pop && (cmd.kind == CMD_READ || cmd.kind == CMD_COPY);

  always_comb begin
    state_next  = state;
    we          = 1'b0;
    waddr       = cmd.wr_slot;
    wdata       = cmd.data;
    load        = 1'b0;
    load_data   = '0;
    load_status = cmd.status;
    case (state)
      BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
        if (clr_cnt == SLOT_W'(STORE_DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (cmd_pop) begin
          if (re) begin
            state_next = BK_WAIT;
          end else begin
            we   = (cmd.kind == CMD_WRITE);
            load = 1'b1;
          end
        end
      end
      BK_WAIT: begin
        // read data is back; a copy writes it to its target slot
        we          = (held_kind == CMD_COPY);
        waddr       = held_wr_slot;
        wdata       = rdata;
        load        = 1'b1;
        load_data   = (held_kind == CMD_READ) ? rdata : '0;
        load_status = ST_OK;
        state_next  = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      held_kind    <= cmd.kind;
      held_wr_slot <= cmd.wr_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data   <= load_data;
      rsp_status <= load_status;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_data;
  assign rsp.status    = rsp_status;

  rds_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (cmd.rd_slot),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

/* rtl/rotating_drum_store_unit.sv */
// Each request is registered in the front end, queued, and answered from the
// back-end output register; reads and copies also pass BK_WAIT for the RAM read
// and hold off the next command; others follow while the result slot is free.
// Reset: synchronous; after reset the store is swept to zero (one word per cycle)
// with req.ready low; config writes are taken throughout.
// ----------------------------------------------------------------------------
// Rotating drum store unit
// Top level: config register, front end, command queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rotating_drum_store_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  rds_req_if.sink                             req,
  rds_rsp_if.source                           rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rds_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rds_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rds_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);
  import rds_pkg::*;

  logic                 drum_large;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic                 clearing;
  logic                 push_valid;
  logic                 push_ready;
  cmd_t                 push_cmd;
  logic                 pop_valid;
  logic                 pop;
  cmd_t                 pop_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drum_large <= 1'b0;
    end else if (cfg_wr && reg_idx == REG_DRUM_LARGE) begin
      drum_large <= pwdata[0];
    end
  end

  assign prdata = (reg_idx == REG_DRUM_LARGE) ? CFG_DATA_W'(drum_large) : '0;

  rds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .clearing   (clearing),
    .drum_large (drum_large),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  rds_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  rds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .cmd       (pop_cmd),
    .clearing  (clearing),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
